// ===== hw/rtl/tssc_pkg.sv =====
// package for the texture surface size calculator
// holds the format decode types, status codes and the format lookup function
package tssc_pkg;

  localparam int unsigned WidthW  = 16;
  localparam int unsigned HeightW = 16;
  localparam int unsigned FormatW = 8;
  localparam int unsigned TotalW  = 36;
  localparam int unsigned RowW    = 20;
  localparam int unsigned RowsW   = 17;
  localparam int unsigned StatusW = 2;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_BADFMT   = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    KIND_BPP    = 3'd0,
    KIND_BLOCK  = 3'd1,
    KIND_PACKED = 3'd2,
    KIND_PLANAR = 3'd3,
    KIND_NV11   = 3'd4,
    KIND_BAD    = 3'd5
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [4:0] bpe;  // bytes per block or per pixel pair
    logic [7:0] bpp;  // bits per pixel for the generic case
  } fmt_t;

  function automatic logic [7:0] bits_per_pixel(input logic [FormatW-1:0] f);
    logic [7:0] b;
    b = 8'd0;
    if (f >= 8'd1 && f <= 8'd4)          b = 8'd128;
    else if (f >= 8'd5 && f <= 8'd8)     b = 8'd96;
    else if (f >= 8'd9 && f <= 8'd22)    b = 8'd64;
    else if (f >= 8'd23 && f <= 8'd47)   b = 8'd32;
    else if (f >= 8'd48 && f <= 8'd59)   b = 8'd16;
    else if (f >= 8'd60 && f <= 8'd65)   b = 8'd8;
    else if (f == 8'd66)                 b = 8'd1;
    else if (f >= 8'd67 && f <= 8'd69)   b = 8'd32;
    else if (f >= 8'd70 && f <= 8'd72)   b = 8'd4;
    else if (f >= 8'd73 && f <= 8'd78)   b = 8'd8;
    else if (f >= 8'd79 && f <= 8'd81)   b = 8'd4;
    else if (f >= 8'd82 && f <= 8'd84)   b = 8'd8;
    else if (f == 8'd85 || f == 8'd86)   b = 8'd16;
    else if (f >= 8'd87 && f <= 8'd93)   b = 8'd32;
    else if (f >= 8'd94 && f <= 8'd99)   b = 8'd8;
    else if (f == 8'd100 || f == 8'd101) b = 8'd32;
    else if (f == 8'd102)                b = 8'd64;
    else if (f == 8'd103)                b = 8'd12;
    else if (f == 8'd104 || f == 8'd105) b = 8'd24;
    else if (f == 8'd106)                b = 8'd12;
    else if (f == 8'd107)                b = 8'd32;
    else if (f == 8'd108 || f == 8'd109) b = 8'd64;
    else if (f == 8'd110)                b = 8'd12;
    else if (f >= 8'd111 && f <= 8'd113) b = 8'd8;
    else if (f == 8'd114 || f == 8'd115) b = 8'd16;
    else if (f == 8'd130 || f == 8'd131) b = 8'd16;
    else if (f == 8'd132)                b = 8'd24;
    return b;
  endfunction

  function automatic fmt_t decode_format(input logic [FormatW-1:0] f);
    fmt_t r;
    r.kind = KIND_BPP;
    r.bpe  = 5'd0;
    r.bpp  = bits_per_pixel(f);
    if ((f >= 8'd70 && f <= 8'd72) || (f >= 8'd79 && f <= 8'd81)) begin
      r.kind = KIND_BLOCK;
      r.bpe  = 5'd8;
    end else if ((f >= 8'd73 && f <= 8'd78) || (f >= 8'd82 && f <= 8'd84) ||
                 (f >= 8'd94 && f <= 8'd99)) begin
      r.kind = KIND_BLOCK;
      r.bpe  = 5'd16;
    end else if (f == 8'd68 || f == 8'd69 || f == 8'd107) begin
      r.kind = KIND_PACKED;
      r.bpe  = 5'd4;
    end else if (f == 8'd108 || f == 8'd109) begin
      r.kind = KIND_PACKED;
      r.bpe  = 5'd8;
    end else if (f == 8'd103 || f == 8'd106 || f == 8'd130) begin
      r.kind = KIND_PLANAR;
      r.bpe  = 5'd2;
    end else if (f == 8'd104 || f == 8'd105) begin
      r.kind = KIND_PLANAR;
      r.bpe  = 5'd4;
    end else if (f == 8'd110) begin
      r.kind = KIND_NV11;
    end else if (r.bpp == 8'd0) begin
      r.kind = KIND_BAD;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/tssc_req_if.sv =====
// request channel of the surface size calculator: valid/ready plus one query
// depends on tssc_pkg for the field widths
interface tssc_req_if;
  import tssc_pkg::*;

  logic               valid;
  logic               ready;
  logic [WidthW-1:0]  surface_width;
  logic [HeightW-1:0] surface_height;
  logic [FormatW-1:0] pixel_format;

  modport source (output valid, surface_width, surface_height, pixel_format,
                  input ready);
  modport sink   (input valid, surface_width, surface_height, pixel_format,
                  output ready);
endinterface

// ===== hw/rtl/tssc_rsp_if.sv =====
// response channel of the surface size calculator: valid/ready plus one result
// depends on tssc_pkg for the field widths
interface tssc_rsp_if;
  import tssc_pkg::*;

  logic               valid;
  logic               ready;
  logic [TotalW-1:0]  total_bytes;
  logic [RowW-1:0]    bytes_per_row;
  logic [RowsW-1:0]   row_total;
  logic [StatusW-1:0] status;

  modport source (output valid, total_bytes, bytes_per_row, row_total, status,
                  input ready);
  modport sink   (input valid, total_bytes, bytes_per_row, row_total, status,
                  output ready);
endinterface

// ===== hw/rtl/texture_surface_size_calc.sv =====
// Surface size calculator: each request beat (width, height, DXGI format code)
// gives one response beat with the row pitch in bytes, the row count and the
// total byte size, plus a status (ok, unknown format, total above 32 bits).
// Three register stages: format decode and row pitch, then the 20x17 row
// multiply, then the planar chroma add and overflow check, which is also the
// output register. One beat is taken every cycle unless a full pipeline is
// stalled, and a stalled response holds it without losing or repeating beats.
// depends on tssc_pkg, tssc_req_if and tssc_rsp_if
module texture_surface_size_calc (
  input  logic clk_i,
  input  logic rst_ni,
  tssc_req_if.sink   req_i,
  tssc_rsp_if.source rsp_o
);
  import tssc_pkg::*;

  // stage handshake
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  assign rdy3        = !v3_q || rsp_o.ready;
  assign rdy2        = !v2_q || rdy3;
  assign rdy1        = !v1_q || rdy2;
  assign req_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= req_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // stage 1: decode, row pitch, multiplier and row count
  fmt_t              fmt;
  logic [RowW-1:0]   row1_d;
  logic [RowsW-1:0]  mult1_d, rows1_d;
  logic [16:0]       w_pair, h_ext, h_half;
  logic [14:0]       w_blk, h_blk;
  logic [23:0]       bits_sum;
  logic [17:0]       nv11_row;

  logic [RowW-1:0]   row1_q;
  logic [RowsW-1:0]  mult1_q, rows1_q;
  logic              planar1_q, bad1_q;

  always_comb begin
    fmt      = decode_format(req_i.pixel_format);
    h_ext    = {1'b0, req_i.surface_height};
    w_pair   = ({1'b0, req_i.surface_width} + 17'd1) >> 1;
    h_half   = (h_ext + 17'd1) >> 1;
    // a zero size stays zero through the round-up to whole blocks
    w_blk    = 15'(({1'b0, req_i.surface_width} + 17'd3) >> 2);
    h_blk    = 15'((h_ext + 17'd3) >> 2);
    nv11_row = {1'b0, w_blk, 2'b00};
    bits_sum = 24'(req_i.surface_width * fmt.bpp) + 24'd7;
    row1_d   = '0;
    mult1_d  = '0;
    rows1_d  = '0;
    unique case (fmt.kind)
      KIND_BLOCK: begin
        row1_d  = RowW'(w_blk * fmt.bpe);
        mult1_d = RowsW'(h_blk);
        rows1_d = RowsW'(h_blk);
      end
      KIND_PACKED: begin
        row1_d  = RowW'(w_pair * fmt.bpe);
        mult1_d = h_ext;
        rows1_d = h_ext;
      end
      KIND_PLANAR: begin
        row1_d  = RowW'(w_pair * fmt.bpe);
        mult1_d = h_ext;
        rows1_d = h_ext + h_half;
      end
      KIND_NV11: begin
        row1_d  = RowW'(nv11_row);
        mult1_d = {req_i.surface_height, 1'b0};
        rows1_d = {req_i.surface_height, 1'b0};
      end
      KIND_BPP: begin
        row1_d  = bits_sum[RowW+2:3];
        mult1_d = h_ext;
        rows1_d = h_ext;
      end
      default: begin
        row1_d  = '0;
        mult1_d = '0;
        rows1_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && req_i.valid) begin
      row1_q    <= row1_d;
      mult1_q   <= mult1_d;
      rows1_q   <= rows1_d;
      planar1_q <= (fmt.kind == KIND_PLANAR);
      bad1_q    <= (fmt.kind == KIND_BAD);
    end
  end

  // stage 2: row pitch times row multiplier
  logic [TotalW-1:0] prod2_q;
  logic [RowW-1:0]   row2_q;
  logic [RowsW-1:0]  rows2_q;
  logic              planar2_q, bad2_q;

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      prod2_q   <= TotalW'(row1_q * mult1_q);
      row2_q    <= row1_q;
      rows2_q   <= rows1_q;
      planar2_q <= planar1_q;
      bad2_q    <= bad1_q;
    end
  end

  // stage 3: half-size chroma plane and 32-bit range check
  logic [TotalW-1:0]  total3_d;
  logic [StatusW-1:0] status3_d;
  logic [TotalW-1:0]  total3_q;
  logic [RowW-1:0]    row3_q;
  logic [RowsW-1:0]   rows3_q;
  logic [StatusW-1:0] status3_q;

  always_comb begin
    total3_d = planar2_q ? prod2_q + ((prod2_q + TotalW'(1)) >> 1) : prod2_q;
    priority if (bad2_q) begin
      status3_d = ST_BADFMT;
    end else if (|total3_d[TotalW-1:32]) begin
      status3_d = ST_OVERFLOW;
    end else begin
      status3_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      total3_q  <= total3_d;
      row3_q    <= row2_q;
      rows3_q   <= rows2_q;
      status3_q <= status3_d;
    end
  end

  assign rsp_o.valid         = v3_q;
  assign rsp_o.total_bytes   = total3_q;
  assign rsp_o.bytes_per_row = row3_q;
  assign rsp_o.row_total     = rows3_q;
  assign rsp_o.status        = status3_q;

endmodule

// ===== dv/texture_surface_size_calc_tb.sv =====
`timescale 1ns / 1ps
// testbench for texture_surface_size_calc: drives size queries with random gaps and stalls,
// predicts each result and compares it with the response beat
// depends on tssc_pkg, tssc_req_if, tssc_rsp_if and the rtl of the block
module texture_surface_size_calc_tb;
  import tssc_pkg::*;

  typedef struct packed {
    logic [TotalW-1:0] total_bytes;
    logic [RowW-1:0]   bytes_per_row;
    logic [RowsW-1:0]  row_total;
    status_e           status;
  } surf_size_t;

  localparam int unsigned IdlePct = 38;

  // codes that leave the bits-per-pixel path
  localparam logic [7:0] SpecialFmts [0:24] = '{
    8'd70, 8'd71, 8'd72, 8'd79, 8'd80, 8'd81, 8'd73, 8'd76, 8'd78, 8'd82,
    8'd84, 8'd94, 8'd97, 8'd99, 8'd68, 8'd69, 8'd107, 8'd108, 8'd109, 8'd103,
    8'd106, 8'd130, 8'd104, 8'd105, 8'd110
  };

  logic clk_i;
  logic rst_ni;

  tssc_req_if req_if ();
  tssc_rsp_if rsp_if ();

  texture_surface_size_calc dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  surf_size_t expected_sizes[$];
  int unsigned mismatch_count;
  bit src_idle;
  bit snk_idle;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("texture_surface_size_calc: mismatch");
    $finish;
  end

  function automatic surf_size_t calc_surface(input logic [WidthW-1:0] w,
                                              input logic [HeightW-1:0] h,
                                              input logic [FormatW-1:0] f);
    logic [63:0] w64, h64, row, rows, total, bpe, bpp;
    kind_e kind;
    surf_size_t r;
    w64 = 64'(w);
    h64 = 64'(h);
    row = 64'd0;
    rows = 64'd0;
    total = 64'd0;
    bpe = 64'd0;
    bpp = 64'd0;
    kind = KIND_BPP;
    r.status = ST_OK;

    if ((f >= 70 && f <= 72) || (f >= 79 && f <= 81)) begin
      kind = KIND_BLOCK;
      bpe = 64'd8;
    end else if ((f >= 73 && f <= 78) || (f >= 82 && f <= 84) || (f >= 94 && f <= 99)) begin
      kind = KIND_BLOCK;
      bpe = 64'd16;
    end else if (f == 68 || f == 69 || f == 107) begin
      kind = KIND_PACKED;
      bpe = 64'd4;
    end else if (f == 108 || f == 109) begin
      kind = KIND_PACKED;
      bpe = 64'd8;
    end else if (f == 103 || f == 106 || f == 130) begin
      kind = KIND_PLANAR;
      bpe = 64'd2;
    end else if (f == 104 || f == 105) begin
      kind = KIND_PLANAR;
      bpe = 64'd4;
    end else if (f == 110) begin
      kind = KIND_NV11;
    end

    case (kind)
      KIND_BLOCK: begin
        // 4x4 blocks, a nonzero size always rounds up to at least one block
        row = ((w64 + 64'd3) >> 2) * bpe;
        rows = (h64 + 64'd3) >> 2;
        total = row * rows;
      end
      KIND_PACKED: begin
        row = ((w64 + 64'd1) >> 1) * bpe;
        rows = h64;
        total = row * h64;
      end
      KIND_NV11: begin
        row = ((w64 + 64'd3) >> 2) * 64'd4;
        rows = h64 * 64'd2;
        total = row * rows;
      end
      KIND_PLANAR: begin
        // luma plane plus a half-height chroma plane
        row = ((w64 + 64'd1) >> 1) * bpe;
        total = row * h64 + ((row * h64 + 64'd1) >> 1);
        rows = h64 + ((h64 + 64'd1) >> 1);
      end
      default: begin
        if (f >= 1 && f <= 4) bpp = 128;
        else if (f >= 5 && f <= 8) bpp = 96;
        else if (f >= 9 && f <= 22) bpp = 64;
        else if (f >= 23 && f <= 47) bpp = 32;
        else if (f >= 48 && f <= 59) bpp = 16;
        else if (f >= 60 && f <= 65) bpp = 8;
        else if (f == 66) bpp = 1;
        else if (f >= 67 && f <= 69) bpp = 32;
        else if (f >= 85 && f <= 86) bpp = 16;
        else if (f >= 87 && f <= 93) bpp = 32;
        else if (f == 100 || f == 101) bpp = 32;
        else if (f == 102) bpp = 64;
        else if (f >= 111 && f <= 113) bpp = 8;
        else if (f == 114 || f == 115) bpp = 16;
        else if (f == 131) bpp = 16;
        else if (f == 132) bpp = 24;
        if (bpp == 64'd0) begin
          r.status = ST_BADFMT;
        end else begin
          row = (w64 * bpp + 64'd7) >> 3;
          rows = h64;
          total = row * h64;
        end
      end
    endcase

    if (r.status == ST_OK && total > 64'hFFFF_FFFF) r.status = ST_OVERFLOW;
    r.total_bytes = total[TotalW-1:0];
    r.bytes_per_row = row[RowW-1:0];
    r.row_total = rows[RowsW-1:0];
    return r;
  endfunction

  // one request beat; returns at the edge that accepts it
  task automatic send_query(input logic [WidthW-1:0] w, input logic [HeightW-1:0] h,
                            input logic [FormatW-1:0] f);
    if (src_idle) begin
      while ($urandom_range(0, 99) < IdlePct) begin
        req_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    req_if.valid <= 1'b1;
    req_if.surface_width <= w;
    req_if.surface_height <= h;
    req_if.pixel_format <= f;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    expected_sizes.push_back(calc_surface(w, h, f));
  endtask

  function automatic logic [15:0] pick_dim();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) return 16'($urandom_range(0, 64));
    if (sel < 70) return 16'($urandom);
    if (sel < 85) return 16'($urandom_range(65528, 65535));
    return 16'((32'd1 << $urandom_range(0, 15)) + $urandom_range(0, 2) - 1);
  endfunction

  task automatic send_random_query();
    int unsigned sel;
    logic [7:0] f;
    sel = $urandom_range(0, 99);
    if (sel < 12) f = 8'($urandom_range(0, 255));
    else if (sel < 30) f = SpecialFmts[$urandom_range(0, 24)];
    else if (sel < 34) f = 8'($urandom_range(130, 132));
    else f = 8'($urandom_range(1, 115));
    send_query(pick_dim(), pick_dim(), f);
  endtask

  task automatic wait_results_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_sizes.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    src_idle = 1'b1;
    snk_idle = 1'b1;
    send_query(16'd0, 16'd0, 8'd28);          // empty surface
    send_query(16'd0, 16'd17, 8'd28);
    send_query(16'd17, 16'd0, 8'd71);
    send_query(16'd1, 16'd1, 8'd71);          // one block minimum
    send_query(16'd5, 16'd7, 8'd77);
    send_query(16'hFFFF, 16'hFFFF, 8'd98);
    send_query(16'hFFFF, 16'hFFFF, 8'd2);     // widest row, total over 32 bits
    send_query(16'hFFFF, 16'd1, 8'd2);
    send_query(16'd3, 16'd5, 8'd68);          // pixel pairs
    send_query(16'hFFFF, 16'hFFFF, 8'd108);
    send_query(16'd1, 16'd1, 8'd103);         // planar with chroma plane
    send_query(16'hFFFF, 16'hFFFF, 8'd104);
    send_query(16'd7, 16'd3, 8'd130);
    send_query(16'd1, 16'd1, 8'd110);         // four-pixel groups, doubled rows
    send_query(16'hFFFF, 16'hFFFF, 8'd110);
    send_query(16'd9, 16'd9, 8'd66);          // one bit per pixel
    send_query(16'hFFFF, 16'd3, 8'd66);
    send_query(16'hFFFF, 16'd16384, 8'd28);   // just fits 32 bits
    send_query(16'hFFFF, 16'd16385, 8'd28);   // just over
    send_query(16'd100, 16'd100, 8'd0);       // unknown codes
    send_query(16'd100, 16'd100, 8'd116);
    send_query(16'hFFFF, 16'hFFFF, 8'd129);
    send_query(16'd5, 16'd5, 8'd133);
    send_query(16'd1, 16'd1, 8'hFF);
  endtask

  task automatic test_random_streaming(input int unsigned n);
    src_idle = 1'b0;
    snk_idle = 1'b0;
    repeat (n) send_random_query();
  endtask

  task automatic test_random_stalls(input int unsigned n);
    src_idle = 1'b1;
    snk_idle = 1'b1;
    repeat (n) send_random_query();
  endtask

  task automatic test_drain_pause();
    src_idle = 1'b1;
    snk_idle = 1'b1;
    repeat (30) send_random_query();
    wait_results_drained();
    repeat (30) send_random_query();
  endtask

  // response checker
  always @(posedge clk_i) begin : check_beat
    surf_size_t exp_r;
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (expected_sizes.size() == 0) begin
        $error("unexpected response beat: total_bytes %0d", rsp_if.total_bytes);
        mismatch_count++;
      end else begin
        exp_r = expected_sizes.pop_front();
        if (rsp_if.total_bytes !== exp_r.total_bytes) begin
          $error("total_bytes: expected %0d, got %0d", exp_r.total_bytes, rsp_if.total_bytes);
          mismatch_count++;
        end
        if (rsp_if.bytes_per_row !== exp_r.bytes_per_row) begin
          $error("bytes_per_row: expected %0d, got %0d", exp_r.bytes_per_row,
                 rsp_if.bytes_per_row);
          mismatch_count++;
        end
        if (rsp_if.row_total !== exp_r.row_total) begin
          $error("row_total: expected %0d, got %0d", exp_r.row_total, rsp_if.row_total);
          mismatch_count++;
        end
        if (rsp_if.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, rsp_if.status);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    rsp_if.ready <= snk_idle ? ($urandom_range(0, 99) >= IdlePct) : 1'b1;
  end

  initial begin
    mismatch_count = 0;
    src_idle = 1'b1;
    snk_idle = 1'b1;
    rst_ni <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.surface_width <= '0;
    req_if.surface_height <= '0;
    req_if.pixel_format <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_streaming(400);
    test_random_stalls(700);
    test_drain_pause();
    test_random_stalls(660);

    wait_results_drained();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && expected_sizes.size() == 0) begin
      $display("texture_surface_size_calc: match");
    end else begin
      $display("texture_surface_size_calc: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tssc_pkg.sv
hw/rtl/tssc_req_if.sv
hw/rtl/tssc_rsp_if.sv
hw/rtl/texture_surface_size_calc.sv
dv/texture_surface_size_calc_tb.sv
